// ----- hw/rtl/kvt_pkg.sv -----
// ----------------------------------------------------------------------------
// kvt_pkg
// Shared types and constants of the key/value text tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package kvt_pkg;

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_SLASH   = 3'd1,
        MODE_COMMENT = 3'd2,
        MODE_WORD    = 3'd3,
        MODE_STRING  = 3'd4,
        MODE_ESCAPE  = 3'd5,
        MODE_FAILED  = 3'd6
    } mode_t;

    typedef enum logic [2:0] {
        EV_SEP    = 3'd0,
        EV_BYTE   = 3'd1,
        EV_STREND = 3'd2,
        EV_ACCEPT = 3'd3,
        EV_REJECT = 3'd4
    } ev_t;

    typedef struct packed {
        ev_t        ev;
        logic [7:0] ch;
    } result_t;

    // One queue entry: the one or two results caused by one input item
    typedef struct packed {
        result_t r0;
        result_t r1;
        logic    two;
    } entry_t;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_LBRACE    = 8'h7B;
    localparam logic [7:0] CH_RBRACE    = 8'h7D;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_N         = 8'h6E;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_R         = 8'h72;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_T         = 8'h74;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_SPACE     = 8'h20;

endpackage

`default_nettype wire

// ----- hw/rtl/keyvalue_text_tokenizer.sv -----
// A result passes through the queue and then the output register before it leaves.
// Throughput: one input byte per cycle while the queue is not full; an item
//   with two results takes two output transfers, absorbed by a 4-entry queue.
// Input stalls only when the queue is full, which depends on output back-pressure.
// Reset (rst_n low, asynchronous): scanner idle, nesting zero, queue and output empty.
// ----------------------------------------------------------------------------
// keyvalue_text_tokenizer
// Byte-serial tokenizer for key/value text: braces, bare words, quoted
// strings with escapes, comments; end-of-text gives accept or reject.
// ----------------------------------------------------------------------------
`default_nettype none

module keyvalue_text_tokenizer import kvt_pkg::*; #(
    parameter int MAX_NESTING = 255
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] char_byte
    input  wire logic       s_tuser,   // [0] func
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] char_out
    output logic [2:0]      m_tuser,   // [2:0] event_res
    output logic            m_tlast
);

    logic   q_full, push, pop, q_valid;
    entry_t push_entry, q_entry;

    kvt_front #(
        .MAX_NESTING (MAX_NESTING)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .func       (s_tuser),
        .char_byte  (s_tdata),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    kvt_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .q_valid    (q_valid),
        .pop        (pop),
        .q_entry    (q_entry)
    );

    kvt_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_entry  (q_entry),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/kvt_front.sv -----
// ----------------------------------------------------------------------------
// kvt_front
// Accepts text bytes, runs the scan state machine and nesting counter, and
// pushes the results of each item as one queue entry.
// ----------------------------------------------------------------------------
`default_nettype none

module kvt_front import kvt_pkg::*; #(
    parameter int MAX_NESTING = 255
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic       func,
    input  wire logic [7:0] char_byte,
    input  wire logic       q_full,
    output logic            push,
    output entry_t          push_entry
);

    localparam int LVL_W = $clog2(MAX_NESTING + 1);
    localparam logic [LVL_W-1:0] LVL_MAX = LVL_W'(MAX_NESTING);

    mode_t            mode_reg, mode_next;
    logic [LVL_W-1:0] level_reg, level_next;

    logic             accept;
    logic [1:0]       n_res;
    result_t          r0, r1;
    logic             is_ws, is_brace, brace_open, brace_ok;
    logic [LVL_W-1:0] brace_lvl;
    logic             end_ok;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            level_reg <= '0;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            level_reg <= level_next;
        end
    end

    always_comb
    begin
        is_ws      = char_byte inside {[CH_TAB:CH_CR], CH_SPACE};
        is_brace   = (char_byte == CH_LBRACE) || (char_byte == CH_RBRACE);
        brace_open = (char_byte == CH_LBRACE);
        brace_ok   = brace_open ? (level_reg != LVL_MAX) : (level_reg != '0);
        brace_lvl  = brace_open ? level_reg + LVL_W'(1) : level_reg - LVL_W'(1);
        end_ok     = (mode_reg != MODE_STRING) && (mode_reg != MODE_ESCAPE) &&
                     (mode_reg != MODE_FAILED) && (level_reg == '0);

        mode_next  = mode_reg;
        level_next = level_reg;
        n_res      = 2'd0;
        r0         = '{ev: EV_SEP, ch: 8'h00};
        r1         = '{ev: EV_SEP, ch: 8'h00};

        if (func)
        begin
            // end of text: flush a pending slash word, then give the verdict
            if (mode_reg == MODE_SLASH)
            begin
                n_res = 2'd2;
                r1    = '{ev: end_ok ? EV_ACCEPT : EV_REJECT, ch: 8'h00};
            end
            else
            begin
                n_res = 2'd1;
                r0    = '{ev: end_ok ? EV_ACCEPT : EV_REJECT, ch: 8'h00};
            end
            mode_next  = MODE_IDLE;
            level_next = '0;
        end
        else
        begin
            case (mode_reg)
                MODE_IDLE, MODE_WORD:
                begin
                    if (is_ws)
                    begin
                        mode_next = MODE_IDLE;
                    end
                    else if (is_brace)
                    begin
                        if (brace_ok)
                        begin
                            n_res      = 2'd1;
                            level_next = brace_lvl;
                            mode_next  = MODE_IDLE;
                        end
                        else
                        begin
                            mode_next = MODE_FAILED;
                        end
                    end
                    else if (mode_reg == MODE_IDLE)
                    begin
                        if (char_byte == CH_SLASH)
                        begin
                            mode_next = MODE_SLASH;
                        end
                        else if (char_byte == CH_QUOTE)
                        begin
                            mode_next = MODE_STRING;
                        end
                        else
                        begin
                            n_res     = 2'd1;
                            mode_next = MODE_WORD;
                        end
                    end
                end
                MODE_SLASH:
                begin
                    if (char_byte == CH_SLASH)
                    begin
                        mode_next = MODE_COMMENT;
                    end
                    else
                    begin
                        n_res = 2'd1;
                        if (is_ws)
                        begin
                            mode_next = MODE_IDLE;
                        end
                        else if (is_brace)
                        begin
                            if (brace_ok)
                            begin
                                n_res      = 2'd2;
                                level_next = brace_lvl;
                                mode_next  = MODE_IDLE;
                            end
                            else
                            begin
                                mode_next = MODE_FAILED;
                            end
                        end
                        else
                        begin
                            mode_next = MODE_WORD;
                        end
                    end
                end
                MODE_COMMENT:
                begin
                    if (char_byte == CH_LF)
                    begin
                        mode_next = MODE_IDLE;
                    end
                end
                MODE_STRING:
                begin
                    if (char_byte == CH_QUOTE)
                    begin
                        n_res     = 2'd1;
                        r0        = '{ev: EV_STREND, ch: 8'h00};
                        mode_next = MODE_IDLE;
                    end
                    else if (char_byte == CH_BACKSLASH)
                    begin
                        mode_next = MODE_ESCAPE;
                    end
                    else
                    begin
                        n_res = 2'd1;
                        r0    = '{ev: EV_BYTE, ch: char_byte};
                    end
                end
                MODE_ESCAPE:
                begin
                    n_res     = 2'd1;
                    mode_next = MODE_STRING;
                    if ((char_byte == CH_BACKSLASH) || (char_byte == CH_QUOTE))
                    begin
                        r0 = '{ev: EV_BYTE, ch: char_byte};
                    end
                    else if (char_byte == CH_N)
                    begin
                        r0 = '{ev: EV_BYTE, ch: CH_LF};
                    end
                    else if (char_byte == CH_R)
                    begin
                        r0 = '{ev: EV_BYTE, ch: CH_CR};
                    end
                    else if (char_byte == CH_T)
                    begin
                        r0 = '{ev: EV_BYTE, ch: CH_TAB};
                    end
                    else
                    begin
                        // unknown escape: keep the backslash and the byte
                        n_res = 2'd2;
                        r0    = '{ev: EV_BYTE, ch: CH_BACKSLASH};
                        r1    = '{ev: EV_BYTE, ch: char_byte};
                    end
                end
                default:
                begin
                    mode_next = MODE_FAILED;
                end
            endcase
        end
    end

    assign push       = accept && (n_res != 2'd0);
    assign push_entry = '{r0: r0, r1: r1, two: (n_res == 2'd2)};

endmodule

`default_nettype wire

// ----- hw/rtl/kvt_fifo.sv -----
// ----------------------------------------------------------------------------
// kvt_fifo
// Short queue of result entries between the scanner and the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module kvt_fifo import kvt_pkg::*; (
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push,
    input  entry_t      push_entry,
    output logic        full,
    output logic        q_valid,
    input  wire logic   pop,
    output entry_t      q_entry
);

    entry_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                do_push, do_pop;

    assign full    = (count_reg == QCNT_W'(QDEPTH));
    assign q_valid = (count_reg != '0);
    assign q_entry = mem_reg[rd_ptr_reg];

    assign do_push = push && !full;
    assign do_pop  = pop && q_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? QPTR_W'(wr_ptr_reg + QPTR_W'(1)) : wr_ptr_reg;
        rd_ptr_next = do_pop ? QPTR_W'(rd_ptr_reg + QPTR_W'(1)) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/kvt_back.sv -----
// ----------------------------------------------------------------------------
// kvt_back
// Output stage: takes one queue entry and sends its one or two results as
// separate transactions, marking the final one.
// ----------------------------------------------------------------------------
`default_nettype none

module kvt_back import kvt_pkg::*; (
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   q_valid,
    input  entry_t      q_entry,
    output logic        pop,
    output logic        m_tvalid,
    input  wire logic   m_tready,
    output logic [7:0]  m_tdata,
    output logic [2:0]  m_tuser,
    output logic        m_tlast
);

    logic    valid_reg;
    logic    sel_reg;
    entry_t  ent_reg;
    result_t cur;
    logic    xfer, done;

    assign cur      = sel_reg ? ent_reg.r1 : ent_reg.r0;
    assign m_tvalid = valid_reg;
    assign m_tdata  = cur.ch;
    assign m_tuser  = cur.ev;
    assign m_tlast  = sel_reg || !ent_reg.two;

    assign xfer = valid_reg && m_tready;
    assign done = xfer && m_tlast;
    assign pop  = q_valid && (!valid_reg || done);

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            ent_reg <= q_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            sel_reg   <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                valid_reg <= 1'b1;
                sel_reg   <= 1'b0;
            end
            else if (done)
            begin
                valid_reg <= 1'b0;
                sel_reg   <= 1'b0;
            end
            else if (xfer)
            begin
                // advance to the second result of the entry
                sel_reg <= 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/kvt_checker.sv -----
// ----------------------------------------------------------------------------
// kvt_checker
// Port-level checks of the tokenizer output stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module kvt_checker import kvt_pkg::*; (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic [2:0] m_tuser,
    input wire logic       m_tlast
);

    // hold a stalled transaction
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=>
            m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
        else $error("output changed while stalled");

    a_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != EV_BYTE) |-> (m_tdata == 8'h00))
        else $error("nonzero data on a non-byte event");

    a_verdict_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && ((m_tuser == EV_ACCEPT) || (m_tuser == EV_REJECT)) |-> m_tlast)
        else $error("accept or reject not marked last");

    // the second result of a pair follows at once
    a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid)
        else $error("gap inside a result pair");

endmodule

bind keyvalue_text_tokenizer kvt_checker u_kvt_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire

// ----- sim/keyvalue_text_tokenizer_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// keyvalue_text_tokenizer_tb
// Drives text bytes and end markers into the tokenizer and checks every event
// against a cycle-free token predictor. Directed cases cover whitespace edges,
// braces, words, strings with escapes, comments, lone slashes, errors, the
// nesting limit and one long output hold. Random documents with noise follow,
// under random gaps on both sides.
// ----------------------------------------------------------------------------

module keyvalue_text_tokenizer_tb import kvt_pkg::*;;

    localparam int MAX_DEPTH    = 255;
    localparam int CLK_HALF     = 6;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int RANDOM_ITEMS = 1400;

    typedef struct packed {
        ev_t        ev;
        logic [7:0] ch;
        logic       last;
    } tok_result_t;

    logic       clk      = 1'b0;
    logic       rst_n    = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;   // [7:0] char_byte
    logic       s_tuser  = 1'b0;    // [0] func
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;            // [7:0] char_out
    logic [2:0] m_tuser;            // [2:0] event_res
    logic       m_tlast;

    // Token predictor state
    mode_t       scan_st     = MODE_IDLE;
    int unsigned brace_depth = 0;
    int          item_events;
    tok_result_t token_q[$];

    int  err_cnt     = 0;
    int  useful_cnt  = 0;
    int  cycle_cnt   = 0;
    bit  src_gaps_on = 1'b1;
    bit  sink_stalls_on = 1'b1;
    int  sink_hold_len  = 0;
    int  stall_left     = 0;
    tok_result_t want;

    keyvalue_text_tokenizer #(
        .MAX_NESTING(MAX_DEPTH)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #CLK_HALF clk = ~clk;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic bit is_space(logic [7:0] c);
        return c == CH_SPACE || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic void push_event(ev_t e, logic [7:0] c);
        token_q.push_back('{ev: e, ch: c, last: 1'b0});
        item_events++;
    endfunction

    function automatic void take_brace(logic [7:0] c);
        if (c == CH_LBRACE)
        begin
            if (brace_depth >= MAX_DEPTH)
            begin
                scan_st = MODE_FAILED;
                return;
            end
            brace_depth++;
        end
        else
        begin
            if (brace_depth == 0)
            begin
                scan_st = MODE_FAILED;
                return;
            end
            brace_depth--;
        end
        push_event(EV_SEP, 8'h00);
        scan_st = MODE_IDLE;
    endfunction

    function automatic void predict_tokens(logic f, logic [7:0] c);
        bit          ok;
        tok_result_t tail;
        item_events = 0;
        if (f)
        begin
            if (scan_st == MODE_SLASH)
                push_event(EV_SEP, 8'h00);
            ok = scan_st != MODE_STRING && scan_st != MODE_ESCAPE &&
                 scan_st != MODE_FAILED && brace_depth == 0;
            push_event(ok ? EV_ACCEPT : EV_REJECT, 8'h00);
            scan_st     = MODE_IDLE;
            brace_depth = 0;
        end
        else
        begin
            case (scan_st)
                MODE_IDLE:
                begin
                    if (is_space(c))
                        ;
                    else if (c == CH_SLASH)
                        scan_st = MODE_SLASH;
                    else if (c == CH_LBRACE || c == CH_RBRACE)
                        take_brace(c);
                    else if (c == CH_QUOTE)
                        scan_st = MODE_STRING;
                    else
                    begin
                        push_event(EV_SEP, 8'h00);
                        scan_st = MODE_WORD;
                    end
                end
                MODE_SLASH:
                begin
                    if (c == CH_SLASH)
                        scan_st = MODE_COMMENT;
                    else
                    begin
                        push_event(EV_SEP, 8'h00);
                        if (is_space(c))
                            scan_st = MODE_IDLE;
                        else if (c == CH_LBRACE || c == CH_RBRACE)
                            take_brace(c);
                        else
                            scan_st = MODE_WORD;
                    end
                end
                MODE_COMMENT:
                begin
                    if (c == CH_LF)
                        scan_st = MODE_IDLE;
                end
                MODE_WORD:
                begin
                    if (is_space(c))
                        scan_st = MODE_IDLE;
                    else if (c == CH_LBRACE || c == CH_RBRACE)
                        take_brace(c);
                end
                MODE_STRING:
                begin
                    if (c == CH_QUOTE)
                    begin
                        push_event(EV_STREND, 8'h00);
                        scan_st = MODE_IDLE;
                    end
                    else if (c == CH_BACKSLASH)
                        scan_st = MODE_ESCAPE;
                    else
                        push_event(EV_BYTE, c);
                end
                MODE_ESCAPE:
                begin
                    if (c == CH_BACKSLASH || c == CH_QUOTE)
                        push_event(EV_BYTE, c);
                    else if (c == CH_N)
                        push_event(EV_BYTE, CH_LF);
                    else if (c == CH_R)
                        push_event(EV_BYTE, CH_CR);
                    else if (c == CH_T)
                        push_event(EV_BYTE, CH_TAB);
                    else
                    begin
                        push_event(EV_BYTE, CH_BACKSLASH);
                        push_event(EV_BYTE, c);
                    end
                    scan_st = MODE_STRING;
                end
                default: scan_st = MODE_FAILED;
            endcase
        end
        if (item_events > 0)
        begin
            tail      = token_q.pop_back();
            tail.last = 1'b1;
            token_q.push_back(tail);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Random helpers
    // ------------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] space_byte();
        int r;
        r = $urandom_range(0, 5);
        return (r == 5) ? CH_SPACE : 8'(8'h09 + r);
    endfunction

    function automatic logic [7:0] word_start_byte();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (is_space(c) || c == CH_LBRACE || c == CH_RBRACE || c == CH_SLASH ||
               c == CH_QUOTE);
        return c;
    endfunction

    function automatic logic [7:0] word_body_byte();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (is_space(c) || c == CH_LBRACE || c == CH_RBRACE);
        return c;
    endfunction

    function automatic logic [7:0] plain_string_byte();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (c == CH_QUOTE || c == CH_BACKSLASH);
        return c;
    endfunction

    // ------------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------------
    task automatic send_item(input logic f, input logic [7:0] b);
        int gap;
        gap = src_gaps_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= f;
        s_tdata  <= b;
        do
            @(posedge clk);
        while (!s_tready);
        if (f || scan_st != MODE_FAILED)
            useful_cnt++;
        predict_tokens(f, b);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_item(1'b0, s[i]);
    endtask

    task automatic send_end();
        send_item(1'b1, 8'($urandom_range(0, 255)));
    endtask

    // Drop valid and hold until every predicted event has come out
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (token_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random stalls, plus a long hold on request
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (sink_hold_len > 0)
        begin
            m_tready <= 1'b0;
            sink_hold_len--;
        end
        else if (stall_left > 0)
        begin
            m_tready <= 1'b0;
            stall_left--;
        end
        else if (sink_stalls_on && $urandom_range(0, 7) == 0)
        begin
            m_tready   <= 1'b0;
            stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                      : $urandom_range(8, 40);
        end
        else
            m_tready <= 1'b1;
    end

    // Compare each output transaction with the oldest predicted event
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (token_q.size() == 0)
            begin
                err_cnt++;
                $error("unexpected event: event_res %0d char_out 0x%02h last %0b",
                       m_tuser, m_tdata, m_tlast);
            end
            else
            begin
                want = token_q.pop_front();
                if (m_tuser !== want.ev)
                begin
                    err_cnt++;
                    $error("event_res: expected %0d, actual %0d", want.ev, m_tuser);
                end
                if (m_tdata !== want.ch)
                begin
                    err_cnt++;
                    $error("char_out: expected 0x%02h, actual 0x%02h", want.ch, m_tdata);
                end
                if (m_tlast !== want.last)
                begin
                    err_cnt++;
                    $error("last: expected %0b, actual %0b", want.last, m_tlast);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Whitespace boundaries, high bytes as words, word ended by a brace
    task automatic test_tokens();
        send_item(1'b0, CH_LBRACE);
        send_item(1'b0, CH_TAB);
        send_item(1'b0, 8'h08);
        send_item(1'b0, CH_CR);
        send_item(1'b0, 8'h80);
        send_item(1'b0, 8'h0E);
        send_item(1'b0, CH_SPACE);
        send_item(1'b0, 8'hFF);
        send_item(1'b0, CH_RBRACE);
        send_item(1'b1, 8'hFF);
    endtask

    // Every escape kind, zero and 0xFF bytes inside a string
    task automatic test_strings();
        send_item(1'b0, CH_QUOTE);
        send_item(1'b0, 8'h00);
        send_text("\\\\\\\"\\n\\r\\t\\{");
        send_item(1'b0, 8'hFF);
        send_item(1'b0, CH_QUOTE);
        send_end();
    endtask

    // Comment to newline, lone slash before braces and before the end marker
    task automatic test_comments_slash();
        send_text("//x\n/{/}/");
        send_end();
    endtask

    // Close at depth zero, open depth at end, unterminated string, dangling escape
    task automatic test_errors();
        send_text("}a");
        send_end();
        send_text("{");
        send_end();
        send_text("\"a");
        send_end();
        send_text("\"\\");
        send_end();
    endtask

    // Fill to the nesting limit, step back, then overflow it
    task automatic test_nesting_limit();
        drain_results();
        src_gaps_on = 1'b0;
        repeat (MAX_DEPTH) send_item(1'b0, CH_LBRACE);
        send_item(1'b0, CH_RBRACE);
        send_item(1'b0, CH_LBRACE);
        send_item(1'b0, CH_LBRACE);
        send_item(1'b0, 8'h61);
        send_end();
        src_gaps_on = 1'b1;
    endtask

    // Hold the output long enough that the block backs up and stalls its input
    task automatic test_output_hold();
        drain_results();
        src_gaps_on   = 1'b0;
        sink_hold_len = 300;
        send_item(1'b0, CH_QUOTE);
        repeat (36) send_item(1'b0, plain_string_byte());
        send_item(1'b0, CH_QUOTE);
        send_end();
        drain_results();
        src_gaps_on = 1'b1;
    endtask

    task automatic send_word();
        send_item(1'b0, word_start_byte());
        repeat ($urandom_range(0, 3)) send_item(1'b0, word_body_byte());
    endtask

    task automatic send_string();
        logic [7:0] esc [6];
        esc = '{CH_BACKSLASH, CH_QUOTE, CH_N, CH_R, CH_T, 8'h00};
        send_item(1'b0, CH_QUOTE);
        repeat ($urandom_range(0, 6))
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                esc[5] = 8'($urandom_range(0, 255));
                send_item(1'b0, CH_BACKSLASH);
                send_item(1'b0, esc[$urandom_range(0, 5)]);
            end
            else
                send_item(1'b0, plain_string_byte());
        end
        send_item(1'b0, CH_QUOTE);
    endtask

    task automatic send_comment();
        logic [7:0] c;
        send_text("//");
        repeat ($urandom_range(0, 4))
        begin
            do
                c = 8'($urandom_range(0, 255));
            while (c == CH_LF);
            send_item(1'b0, c);
        end
        send_item(1'b0, CH_LF);
    endtask

    // One document of random tokens; mostly balanced, sometimes left open
    task automatic gen_document();
        int depth;
        depth = 0;
        repeat ($urandom_range(2, 16))
        begin
            case ($urandom_range(0, 9))
                0:
                begin
                    if (depth < 5)
                    begin
                        send_item(1'b0, CH_LBRACE);
                        depth++;
                    end
                    else
                    begin
                        send_item(1'b0, CH_RBRACE);
                        depth--;
                    end
                end
                1:
                begin
                    if (depth > 0)
                    begin
                        send_item(1'b0, CH_RBRACE);
                        depth--;
                    end
                end
                2, 3:    send_word();
                4, 5, 6: send_string();
                7:       send_comment();
                8:       send_item(1'b0, CH_SLASH);
                default: send_item(1'b0, space_byte());
            endcase
            if ($urandom_range(0, 3) != 0)
                send_item(1'b0, space_byte());
        end
        if ($urandom_range(0, 9) != 0)
            repeat (depth) send_item(1'b0, CH_RBRACE);
        send_end();
    endtask

    task automatic gen_noise(input int n);
        repeat (n) send_item(($urandom_range(0, 15) == 0), 8'($urandom_range(0, 255)));
        if ($urandom_range(0, 1) == 0)
            send_end();
    endtask

    task automatic test_random_documents();
        int target;
        target = useful_cnt + RANDOM_ITEMS;
        while (useful_cnt < target)
        begin
            src_gaps_on    = ($urandom_range(0, 3) != 0);
            sink_stalls_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 9) < 8)
                gen_document();
            else
                gen_noise($urandom_range(4, 24));
        end
        src_gaps_on    = 1'b1;
        sink_stalls_on = 1'b1;
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_tokens();
        test_strings();
        test_comments_slash();
        test_errors();
        test_nesting_limit();
        test_output_hold();
        test_random_documents();

        drain_results();
        repeat (20) @(posedge clk);
        if (err_cnt == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/kvt_pkg.sv
hw/rtl/kvt_front.sv
hw/rtl/kvt_fifo.sv
hw/rtl/kvt_back.sv
hw/rtl/keyvalue_text_tokenizer.sv
hw/rtl/kvt_checker.sv
sim/keyvalue_text_tokenizer_tb.sv
